[hdl/pdt_pkg.sv]
// Package: shared types and constants of the palette deduplication table.
package pdt_pkg;

  localparam int CHAN_W   = 8;
  localparam int COLOUR_W = 3 * CHAN_W;
  localparam int IDX_W    = 6;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_COPY,
    ST_FINISH
  } state_t;

  // Request to the shared compare unit for one stored palette.
  typedef struct packed {
    logic valid;
    logic first_pos;
    logic last_pos;
  } cmp_req_t;

  // Flag update and hit report from the compare unit.
  typedef struct packed {
    logic flag_wr;
    logic flag;
    logic hit;
  } cmp_rsp_t;

endpackage

[hdl/pdt_in_if.sv]
// Interface: input channel carrying one colour push or a clear.
interface pdt_in_if import pdt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;

  modport source (output valid, output op, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input op, input red, input green, input blue,
                  output ready);
endinterface

[hdl/pdt_out_if.sv]
// Interface: output channel carrying one palette lookup result.
interface pdt_out_if import pdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  palette_index;
  logic              newly_added;
  logic              table_full;

  modport source (output valid, output palette_index, output newly_added,
                  output table_full, input ready);
  modport sink   (input valid, input palette_index, input newly_added,
                  input table_full, output ready);
endinterface

[hdl/pdt_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
module pdt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/pdt_cmp_unit.sv]
// Shared compare unit: one stored colour against the incoming colour per cycle.
module pdt_cmp_unit import pdt_pkg::*; (
  input  cmp_req_t             req,
  input  logic [COLOUR_W-1:0]  stored,
  input  logic [COLOUR_W-1:0]  colour,
  input  logic                 flag_old,
  output cmp_rsp_t             rsp
);

  logic eq;
  logic flag_new;

  always_comb begin
    eq       = (stored == colour);
    // first position starts a fresh match flag, later ones narrow it
    flag_new = req.first_pos ? eq : (flag_old & eq);
    rsp.flag_wr = req.valid;
    rsp.flag    = flag_new;
    rsp.hit     = req.valid && req.last_pos && flag_new;
  end

endmodule

[hdl/palette_dedup_table_unit.sv]
// Top level: palette deduplication table with a sequenced shared compare unit.
// Sequence: each colour is compared against the stored palettes (up to MAX_PALETTES);
//   after the final colour the result is made on a hit or when full, else the
//   incoming palette is first copied into the next free slot; the result then
//   waits for any held result to be taken. A clear empties the table, no result.
// Throughput: a new colour or clear is taken only while the sequencer is idle.
// Reset: synchronous; empties the table, restarts the palette, drops any result.
module palette_dedup_table_unit import pdt_pkg::*; #(
  parameter int MAX_PALETTES    = 64,
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  pdt_in_if.sink    in_ch,
  pdt_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_PALETTES * PALETTE_ENTRIES);
  localparam int IW = (MAX_PALETTES > 1) ? $clog2(MAX_PALETTES) : 1;
  localparam int CW = $clog2(MAX_PALETTES + 1);
  localparam int PW = $clog2(PALETTE_ENTRIES);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PALETTES);
  localparam logic [PW-1:0] LAST_POS = PW'(PALETTE_ENTRIES - 1);
  localparam logic [PW:0]   PE_CNT   = (PW + 1)'(PALETTE_ENTRIES);
  localparam logic [AW:0]   STEP     = (AW + 1)'(PALETTE_ENTRIES);

  // State
  state_t state, state_next;

  logic [CW-1:0]       count;     // stored palettes
  logic [PW-1:0]       pos;       // position of the next colour
  logic [COLOUR_W-1:0] colour;    // colour under comparison
  logic [CW-1:0]       iss;       // compare reads issued
  logic [AW:0]         base;      // iss * PALETTE_ENTRIES, kept by adding
  logic                s1_vld;    // compare stage holds read data
  logic [IW-1:0]       s1_idx;
  logic                hit;
  logic [IW-1:0]       found;
  logic [PW:0]         cj;        // copy reads issued
  logic                c1_vld;    // copy stage holds read data
  logic [PW-1:0]       c1_j;

  logic [IDX_W-1:0]    out_idx;
  logic                out_new;
  logic                out_full;
  logic                out_vld;

  // Control strobes
  logic acc, is_clear, issue_cmp, issue_copy, cmp_done, copy_done, finish_go;

  // Memory and compare unit wiring
  logic [AW:0]         rd_sum, wr_sum;
  logic [COLOUR_W-1:0] store_q, inc_q;
  logic                flag_q;
  cmp_req_t            req;
  cmp_rsp_t            rsp;
  logic [31:0]         found_w, count_w;

  assign in_ch.ready          = (state == ST_IDLE);
  assign out_ch.valid         = out_vld;
  assign out_ch.palette_index = out_idx;
  assign out_ch.newly_added   = out_new;
  assign out_ch.table_full    = out_full;

  assign acc      = in_ch.valid && in_ch.ready;
  assign is_clear = (in_ch.op == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    issue_cmp  = (state == ST_CMP) && (iss < count);
    issue_copy = (state == ST_COPY) && (cj < PE_CNT);
    cmp_done   = (state == ST_CMP) && !issue_cmp && !s1_vld;
    copy_done  = (state == ST_COPY) && !issue_copy && !c1_vld;
    finish_go  = (state == ST_FINISH) && (!out_vld || out_ch.ready);
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && !is_clear) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_done) begin
          if (pos != LAST_POS) state_next = ST_IDLE;
          else if (hit || (count >= MAX_CNT)) state_next = ST_FINISH;
          else state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (copy_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign found_w = 32'(found);
  assign count_w = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pos     <= '0;
      hit     <= 1'b0;
      s1_vld  <= 1'b0;
      c1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      // a new result loading the same cycle keeps valid high
      if (out_vld && out_ch.ready && !finish_go) out_vld <= 1'b0;

      if (acc) begin
        if (is_clear) begin
          count <= '0;
          pos   <= '0;
        end else begin
          colour <= {in_ch.blue, in_ch.green, in_ch.red};
          iss    <= '0;
          base   <= '0;
        end
      end

      // compare pass: one stored palette per cycle, flag update in the cycle after the read
      s1_vld <= issue_cmp;
      if (issue_cmp) begin
        iss    <= iss + 1'b1;
        base   <= base + STEP;
        s1_idx <= iss[IW-1:0];
      end
      if (rsp.hit && !hit) begin
        hit   <= 1'b1;
        found <= s1_idx;
      end
      if (cmp_done) begin
        cj <= '0;
        if (pos != LAST_POS) pos <= pos + 1'b1;
      end

      // copy pass: incoming palette into the next free slot at base
      c1_vld <= issue_copy;
      if (issue_copy) begin
        cj   <= cj + 1'b1;
        c1_j <= cj[PW-1:0];
      end

      if (finish_go) begin
        out_vld <= 1'b1;
        pos     <= '0;
        hit     <= 1'b0;
        if (hit) begin
          out_idx  <= found_w[IDX_W-1:0];
          out_new  <= 1'b0;
          out_full <= 1'b0;
        end else if (count < MAX_CNT) begin
          out_idx  <= count_w[IDX_W-1:0];
          out_new  <= 1'b1;
          out_full <= 1'b0;
          count    <= count + 1'b1;
        end else begin
          out_idx  <= '0;
          out_new  <= 1'b0;
          out_full <= 1'b1;
        end
      end
    end
  end

  assign rd_sum = base + (AW + 1)'(pos);
  assign wr_sum = base + (AW + 1)'(c1_j);

  pdt_ram #(.DEPTH(MAX_PALETTES * PALETTE_ENTRIES), .WIDTH(COLOUR_W), .AW(AW)) u_store (
    .clk   (clk),
    .we    (c1_vld),
    .waddr (wr_sum[AW-1:0]),
    .wdata (inc_q),
    .re    (issue_cmp),
    .raddr (rd_sum[AW-1:0]),
    .rdata (store_q)
  );

  pdt_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(COLOUR_W), .AW(PW)) u_incoming (
    .clk   (clk),
    .we    (acc && !is_clear),
    .waddr (pos),
    .wdata ({in_ch.blue, in_ch.green, in_ch.red}),
    .re    (issue_copy),
    .raddr (cj[PW-1:0]),
    .rdata (inc_q)
  );

  // Match flags: written at the first position without a read, so no clear pass
  pdt_ram #(.DEPTH(MAX_PALETTES), .WIDTH(1), .AW(IW)) u_flags (
    .clk   (clk),
    .we    (rsp.flag_wr),
    .waddr (s1_idx),
    .wdata (rsp.flag),
    .re    (issue_cmp),
    .raddr (iss[IW-1:0]),
    .rdata (flag_q)
  );

  always_comb begin
    req.valid     = s1_vld;
    req.first_pos = (pos == '0);
    req.last_pos  = (pos == LAST_POS);
  end

  pdt_cmp_unit u_cmp (
    .req      (req),
    .stored   (store_q),
    .colour   (colour),
    .flag_old (flag_q),
    .rsp      (rsp)
  );

  // Assertions
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready)
    else $error("input ready while sequencer busy");

  a_copy_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> (count < MAX_CNT) && !hit)
    else $error("copy pass without a free slot or after a hit");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (finish_go && !hit && (count >= MAX_CNT)) |=>
      out_ch.valid && out_ch.table_full && !out_ch.newly_added)
    else $error("full table result malformed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("palette count beyond table size");

endmodule
